### sv/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg
// Shared constants, types and helpers for the calibration record deframer.
// ----------------------------------------------------------------------------
package crd_pkg;

   localparam int CHANNELS      = 1024;
   localparam int GROUPS        = 16;
   localparam int TRAILER_WORDS = 14;

   localparam int DATA_W = 16;
   localparam int MOD_W  = 10;
   localparam int KIND_W = 4;
   localparam int IDX_W  = 10;
   localparam int MASK_W = 11;
   localparam int FILL_W = 2;
   localparam int SEC_N  = 13;

   localparam int LEN_MAX = (CHANNELS > GROUPS)
                            ? ((CHANNELS > TRAILER_WORDS) ? CHANNELS : TRAILER_WORDS)
                            : ((GROUPS > TRAILER_WORDS) ? GROUPS : TRAILER_WORDS);
   localparam int CNT_W   = (LEN_MAX > 2) ? $clog2(LEN_MAX) : 1;

   localparam logic [KIND_W-1:0] KIND_COMMAND = 4'd0;
   localparam logic [KIND_W-1:0] KIND_PED     = 4'd1;
   localparam logic [KIND_W-1:0] KIND_STATUS  = 4'd2;
   localparam logic [KIND_W-1:0] KIND_SIGLOW  = 4'd3;
   localparam logic [KIND_W-1:0] KIND_RAWSIG  = 4'd4;
   localparam logic [KIND_W-1:0] KIND_SIGHI   = 4'd5;
   localparam logic [KIND_W-1:0] KIND_OCC     = 4'd6;
   localparam logic [KIND_W-1:0] KIND_CNRMS   = 4'd7;
   localparam logic [KIND_W-1:0] KIND_CNMEAN  = 4'd8;
   localparam logic [KIND_W-1:0] KIND_NGOCC   = 4'd9;
   localparam logic [KIND_W-1:0] KIND_SIGMA   = 4'd10;
   localparam logic [KIND_W-1:0] KIND_DATAOCC = 4'd11;
   localparam logic [KIND_W-1:0] KIND_TRAILER = 4'd12;

   localparam logic [MASK_W-1:0] MASK_SIGLOW = 11'h004;
   localparam logic [MASK_W-1:0] MASK_SIGMA  = 11'h200;

   localparam logic [FILL_W-1:0] FILL_NONE    = 2'd0;
   localparam logic [FILL_W-1:0] FILL_LEGACY  = 2'd1;
   localparam logic [FILL_W-1:0] FILL_CURRENT = 2'd2;

   typedef enum logic [SEC_N-1:0] {
      S_COMMAND = 13'b0_0000_0000_0001,
      S_PED     = 13'b0_0000_0000_0010,
      S_STATUS  = 13'b0_0000_0000_0100,
      S_SIGLOW  = 13'b0_0000_0000_1000,
      S_RAWSIG  = 13'b0_0000_0001_0000,
      S_SIGHI   = 13'b0_0000_0010_0000,
      S_OCC     = 13'b0_0000_0100_0000,
      S_CNRMS   = 13'b0_0000_1000_0000,
      S_CNMEAN  = 13'b0_0001_0000_0000,
      S_NGOCC   = 13'b0_0010_0000_0000,
      S_SIGMA   = 13'b0_0100_0000_0000,
      S_DATAOCC = 13'b0_1000_0000_0000,
      S_TRAILER = 13'b1_0000_0000_0000
   } sec_type;

   function automatic logic [KIND_W-1:0] sec_kind(input sec_type s);
      logic [KIND_W-1:0] k;
      case (s)
         S_PED:     k = KIND_PED;
         S_STATUS:  k = KIND_STATUS;
         S_SIGLOW:  k = KIND_SIGLOW;
         S_RAWSIG:  k = KIND_RAWSIG;
         S_SIGHI:   k = KIND_SIGHI;
         S_OCC:     k = KIND_OCC;
         S_CNRMS:   k = KIND_CNRMS;
         S_CNMEAN:  k = KIND_CNMEAN;
         S_NGOCC:   k = KIND_NGOCC;
         S_SIGMA:   k = KIND_SIGMA;
         S_DATAOCC: k = KIND_DATAOCC;
         S_TRAILER: k = KIND_TRAILER;
         default:   k = KIND_COMMAND;
      endcase
      return k;
   endfunction

   function automatic sec_type kind_sec(input logic [KIND_W-1:0] k);
      return sec_type'({{(SEC_N-1){1'b0}}, 1'b1} << k);
   endfunction

   function automatic logic [CNT_W-1:0] sec_last(input logic [KIND_W-1:0] k);
      logic [CNT_W-1:0] l;
      case (k) inside
         KIND_CNRMS, KIND_CNMEAN: l = CNT_W'(GROUPS - 1);
         KIND_TRAILER:            l = CNT_W'(TRAILER_WORDS - 1);
         default:                 l = CNT_W'(CHANNELS - 1);
      endcase
      return l;
   endfunction

   // first enabled section at or above 'from', else trailer
   function automatic logic [KIND_W-1:0] next_kind(input logic [MASK_W-1:0] mask,
                                                   input logic [KIND_W-1:0] from);
      logic [KIND_W-1:0] k;
      k = KIND_TRAILER;
      for (int s = MASK_W; s >= 1; s--) begin
         if ((KIND_W'(s) >= from) && mask[s-1]) begin
            k = KIND_W'(s);
         end
      end
      return k;
   endfunction

endpackage

### sv/crd_if.sv
// ----------------------------------------------------------------------------
// crd_req_if / crd_rsp_if
// Valid/ready channels for record words and tagged result words.
// ----------------------------------------------------------------------------
interface crd_req_if;
   import crd_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_word;
   logic [MOD_W-1:0]  module_id;

   modport source (output valid, output data_word, output module_id, input ready);
   modport sink   (input valid, input data_word, input module_id, output ready);
endinterface

interface crd_rsp_if;
   import crd_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] word_kind;
   logic [IDX_W-1:0]  element_index;
   logic [DATA_W-1:0] word_value;
   logic [MOD_W-1:0]  module_tag;
   logic              record_end;
   logic [MASK_W-1:0] section_mask;
   logic [FILL_W-1:0] fill_mode;

   modport source (output valid, output word_kind, output element_index,
                   output word_value, output module_tag, output record_end,
                   output section_mask, output fill_mode, input ready);
   modport sink   (input valid, input word_kind, input element_index,
                   input word_value, input module_tag, input record_end,
                   input section_mask, input fill_mode, output ready);
endinterface

### sv/calibration_record_deframer.sv
// ----------------------------------------------------------------------------
// calibration_record_deframer
// Tags each word of a calibration record with its section kind and index.
// ----------------------------------------------------------------------------
// rsp valid rises in the cycle after the req transaction (single result register).
// Throughput: one word per cycle; req stays ready while the result register
//   is empty or being drained in the same cycle.
// Reset (synchronous): rsp valid clears, the section tracker returns to the
//   command word state with zero count and zero mask.
module calibration_record_deframer (
   input  logic          clock,
   input  logic          reset,
   crd_req_if.sink       req_ch,
   crd_rsp_if.source     rsp_ch
);
   import crd_pkg::*;

   sec_type           sec_ff, sec_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MASK_W-1:0] mask_ff, mask_in;

   logic              rsp_valid_ff;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [DATA_W-1:0] word_ff;
   logic [MOD_W-1:0]  mod_ff;
   logic              end_ff, end_in;
   logic [MASK_W-1:0] omask_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic              accept;
   logic [KIND_W-1:0] cur_kind;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign cur_kind     = sec_kind(sec_ff);

   always_comb begin
      mask_in = mask_ff;
      cnt_in  = cnt_ff;
      sec_in  = sec_ff;
      kind_in = cur_kind;
      idx_in  = IDX_W'({{IDX_W{1'b0}}, cnt_ff});
      end_in  = 1'b0;
      fill_in = FILL_NONE;
      if (cur_kind == KIND_COMMAND) begin
         mask_in = req_ch.data_word[MASK_W-1:0];
         cnt_in  = '0;
         idx_in  = '0;
         sec_in  = kind_sec(next_kind(mask_in, KIND_PED));
      end else if (cnt_ff >= sec_last(cur_kind)) begin
         cnt_in = '0;
         if (cur_kind == KIND_TRAILER) begin
            end_in = 1'b1;
            sec_in = S_COMMAND;
            if ((mask_ff & MASK_SIGMA) != '0) begin
               fill_in = FILL_CURRENT;
            end else if ((mask_ff & MASK_SIGLOW) != '0) begin
               fill_in = FILL_LEGACY;
            end
         end else begin
            sec_in = kind_sec(next_kind(mask_ff, KIND_W'(cur_kind + KIND_W'(1))));
         end
      end else begin
         cnt_in = CNT_W'(cnt_ff + CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff       <= S_COMMAND;
         cnt_ff       <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            sec_ff  <= sec_in;
            cnt_ff  <= cnt_in;
            mask_ff <= mask_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= kind_in;
         idx_ff   <= idx_in;
         word_ff  <= req_ch.data_word;
         mod_ff   <= req_ch.module_id;
         end_ff   <= end_in;
         omask_ff <= mask_in;
         fill_ff  <= fill_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.word_kind     = kind_ff;
   assign rsp_ch.element_index = idx_ff;
   assign rsp_ch.word_value    = word_ff;
   assign rsp_ch.module_tag    = mod_ff;
   assign rsp_ch.record_end    = end_ff;
   assign rsp_ch.section_mask  = omask_ff;
   assign rsp_ch.fill_mode     = fill_ff;

   a_end_is_trailer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && end_ff |-> kind_ff == KIND_TRAILER)
      else $error("record end on a non-trailer word");

   a_fill_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !end_ff |-> fill_ff == FILL_NONE)
      else $error("fill mode set before record end");

   a_command_leaves: assert property (@(posedge clock) disable iff (reset)
      accept && sec_ff == S_COMMAND |=> sec_ff != S_COMMAND)
      else $error("command word did not advance the section");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_kind != KIND_COMMAND |-> cnt_ff <= sec_last(cur_kind))
      else $error("element counter beyond section length");

   a_trailer_end_back: assert property (@(posedge clock) disable iff (reset)
      accept && end_in |=> sec_ff == S_COMMAND && cnt_ff == '0)
      else $error("tracker not back at command after trailer");

endmodule

### tb/deframe_checker.sv
// ----------------------------------------------------------------------------
// deframe_checker
// Watches the record word and result channels of the calibration record
// deframer. It predicts the kind, index, mask and fill mode of every accepted
// word and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module deframe_checker (
   input  logic clock,
   input  logic reset,
   crd_req_if   req_mon,
   crd_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import crd_pkg::*;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] value;
      logic [MOD_W-1:0]  tag;
      logic              last;
      logic [MASK_W-1:0] mask;
      logic [FILL_W-1:0] fill;
   } deframed_type;

   deframed_type      tagged_q[$];
   logic [KIND_W-1:0] sec_now;
   int unsigned       elem_cnt;
   logic [MASK_W-1:0] mask_held;

   function automatic logic [KIND_W-1:0] first_section(input logic [KIND_W-1:0] from);
      for (int s = from; s <= int'(KIND_DATAOCC); s++) begin
         if (mask_held[s-1]) return KIND_W'(s);
      end
      return KIND_TRAILER;
   endfunction

   function automatic int section_words(input logic [KIND_W-1:0] k);
      if (k == KIND_CNRMS || k == KIND_CNMEAN) return GROUPS;
      if (k == KIND_TRAILER) return TRAILER_WORDS;
      return CHANNELS;
   endfunction

   function automatic deframed_type tag_word(input logic [DATA_W-1:0] w,
                                             input logic [MOD_W-1:0]  m);
      deframed_type d;
      d       = '0;
      d.value = w;
      d.tag   = m;
      d.fill  = FILL_NONE;
      if (sec_now == KIND_COMMAND || sec_now > KIND_TRAILER) begin
         mask_held = w[MASK_W-1:0];
         d.kind    = KIND_COMMAND;
         elem_cnt  = 0;
         sec_now   = first_section(KIND_PED);
      end else begin
         d.kind  = sec_now;
         d.index = IDX_W'(elem_cnt);
         if (elem_cnt + 1 >= section_words(sec_now)) begin
            elem_cnt = 0;
            if (sec_now == KIND_TRAILER) begin
               d.last = 1'b1;
               if ((mask_held & MASK_SIGMA) != '0) begin
                  d.fill = FILL_CURRENT;
               end else if ((mask_held & MASK_SIGLOW) != '0) begin
                  d.fill = FILL_LEGACY;
               end
               sec_now = KIND_COMMAND;
            end else begin
               sec_now = first_section(KIND_W'(sec_now + 1));
            end
         end else begin
            elem_cnt++;
         end
      end
      d.mask = mask_held;
      return d;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      deframed_type want;
      if (reset) begin
         sec_now    = KIND_COMMAND;
         elem_cnt   = 0;
         mask_held  = '0;
         fail_count = 0;
         tagged_q.delete();
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            tagged_q.push_back(tag_word(req_mon.data_word, req_mon.module_id));
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (tagged_q.size() == 0) begin
               $error("result transaction with no expected word pending");
               fail_count++;
            end else begin
               want = tagged_q.pop_front();
               check_field("word_kind", 16'(want.kind), 16'(rsp_mon.word_kind));
               check_field("element_index", 16'(want.index), 16'(rsp_mon.element_index));
               check_field("word_value", want.value, rsp_mon.word_value);
               check_field("module_tag", 16'(want.tag), 16'(rsp_mon.module_tag));
               check_field("record_end", 16'(want.last), 16'(rsp_mon.record_end));
               check_field("section_mask", 16'(want.mask), 16'(rsp_mon.section_mask));
               check_field("fill_mode", 16'(want.fill), 16'(rsp_mon.fill_mode));
            end
         end
      end
      pending = tagged_q.size();
   end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives calibration records into the deframer: short directed records with
// empty masks, random records of common-noise tables, then one record with a
// single channel table, sigma-low or sigma, so that a fill mode is reported,
// and a last common-noise record. Both channels idle and stall in random bursts,
// but not during that last record; the checker does the comparison.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import crd_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   sent;
   bit   quiet;

   crd_req_if req_ch ();
   crd_rsp_if rsp_ch ();

   calibration_record_deframer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   deframe_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic send_word(input logic [DATA_W-1:0] w, input logic [MOD_W-1:0] m);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_ch.valid     <= 1'b0;
         req_ch.data_word <= DATA_W'($urandom);
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_word <= w;
      req_ch.module_id <= m;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sent++;
      @(negedge clock);
   endtask

   // command word followed by the section words its mask calls for and the trailer
   task automatic send_record(input logic [DATA_W-1:0] cmd, input logic [MOD_W-1:0] mod_id);
      int words;
      words = TRAILER_WORDS;
      for (int b = 0; b < MASK_W; b++) begin
         if (cmd[b]) begin
            words += (b == KIND_CNRMS - 1 || b == KIND_CNMEAN - 1) ? GROUPS : CHANNELS;
         end
      end
      send_word(cmd, mod_id);
      repeat (words) send_word(DATA_W'($urandom), mod_id);
   endtask

   initial begin : rsp_drain
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   initial begin : stimulus
      logic [DATA_W-1:0] cmd;
      int                pick;
      reset            = 1'b1;
      quiet            = 1'b0;
      sent             = 0;
      req_ch.valid     = 1'b0;
      req_ch.data_word = '0;
      req_ch.module_id = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // high command bits only: empty mask, trailer right after the command
      send_word(16'hF800, 10'h3FF);
      for (int i = 0; i < TRAILER_WORDS; i++) begin
         send_word((i % 2) ? 16'hFFFF : 16'h0000, 10'h3FF);
      end
      send_record(16'h0000, 10'h000);

      repeat (2) send_record(DATA_W'($urandom) & 16'hF8C0, MOD_W'($urandom));

      // sigma-low alone gives the old fill, sigma the new one
      cmd  = DATA_W'($urandom) & 16'hF8C0;
      pick = ($urandom_range(0, 1) == 0) ? int'(KIND_SIGLOW) - 1 : int'(KIND_SIGMA) - 1;
      cmd[pick] = 1'b1;
      send_record(cmd, MOD_W'($urandom));

      quiet = 1'b1;
      send_record(DATA_W'($urandom) & 16'hF8C0, MOD_W'($urandom));
      req_ch.valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #8ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
